FILE: hw/rtl/dts_pkg.sv
// dts_pkg: shared types and constants for the dependency task scheduler.
// No dependencies; used by dts_dep_ram, dts_ctrl and dependency_task_scheduler.
package dts_pkg;

	localparam int FAM_W   = 5;
	localparam int MASK_W  = 32;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [2:0] {
		ACT_LOAD  = 3'd0,
		ACT_RESET = 3'd1,
		ACT_NEXT  = 3'd2,
		ACT_DONE  = 3'd3,
		ACT_RETRY = 3'd4
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRESENT = 1'd0,
		REG_START   = 1'd1
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_WALK = 1'b1
	} sched_state_t;

	typedef struct packed {
		action_t             action;
		logic [FAM_W-1:0]    family;
		logic [MASK_W-1:0]   dep_mask;
	} req_word_t;

	typedef struct packed {
		logic                task_valid;
		logic [FAM_W-1:0]    task_family;
		logic                still_pending;
	} rsp_word_t;

	// dependency table access from the controller
	typedef struct packed {
		logic                wr_en;
		logic [FAM_W-1:0]    wr_addr;
		logic [MASK_W-1:0]   wr_data;
		logic                rd_en;
		logic [FAM_W-1:0]    rd_addr;
	} dep_port_t;

endpackage

FILE: hw/rtl/dependency_task_scheduler.sv
// dependency_task_scheduler: top level; config registers, two-word result queue.
// Depends on dts_pkg, dts_dep_ram and dts_ctrl.
//
//  channel | dir | handshake            | word
//  req     | in  | req_valid/req_stall  | req_word_t  (action, family, dep_mask)
//  rsp     | out | rsp_valid/rsp_stall  | rsp_word_t  (task_valid, task_family, still_pending)
//  cfg     | in  | cfg_we               | cfg_index selects present/start, cfg_data
//
// Finishing a present family walks all min(FAMILIES,32) entries of the dependency table
// one entry per cycle through the table's read port.
// Reset clears the sets, the config registers and the queue; the table needs no clear.
// Every word gives one result; the two-word queue lets req run ahead of a stalled rsp.
module dependency_task_scheduler
	import dts_pkg::*;
#(
	parameter int FAMILIES = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_word_t            req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_word_t            rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MASK_W-1:0]    cfg_data
);

	// families beyond the register width can never be named or marked present
	localparam int SW = (FAMILIES < MASK_W) ? FAMILIES : MASK_W;

	logic [SW-1:0] present_q, start_q;
	logic          accept, busy, pop;
	logic [1:0]    cnt_q;
	rsp_word_t     head_q, tail_q, res;
	logic [MASK_W-1:0] dep_rd_data;
	dep_port_t     dep_port;

	// config writes; only the implemented family bits are kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			start_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_PRESENT: present_q <= cfg_data[SW-1:0];
				REG_START:   start_q   <= cfg_data[SW-1:0];
				default: ;
			endcase
		end
	end

	// a new word waits while the walk runs or both queue slots hold results
	assign req_stall = busy || (cnt_q == 2'd2);
	assign accept    = req_valid && !req_stall;

	assign rsp_valid = (cnt_q != 2'd0);
	assign rsp       = head_q;
	assign pop       = rsp_valid && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({accept, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// head is the word on rsp, tail the one behind it
	always_ff @(posedge clk) begin
		if (accept && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop))) head_q <= res;
		else if (pop) head_q <= tail_q;
		if (accept && (cnt_q != 2'd0) && !pop) tail_q <= res;
	end

	dts_ctrl #(
		.FAMILIES (FAMILIES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.req         (req),
		.present     (present_q),
		.start       (start_q),
		.dep_rd_data (dep_rd_data),
		.dep_port    (dep_port),
		.busy        (busy),
		.res         (res)
	);

	dts_dep_ram #(
		.DEPTH (SW)
	) u_dep_ram (
		.clk     (clk),
		.port    (dep_port),
		.rd_data (dep_rd_data)
	);

endmodule

FILE: hw/rtl/dts_dep_ram.sv
// dts_dep_ram: dependency mask table, one write port, one registered read port.
// Depends on dts_pkg.
module dts_dep_ram
	import dts_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  logic              clk,
	input  dep_port_t         port,
	output logic [MASK_W-1:0] rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [MASK_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (port.wr_en) begin
			mem_q[port.wr_addr[AW-1:0]] <= port.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (port.rd_en) begin
			rd_data <= mem_q[port.rd_addr[AW-1:0]];
		end
	end

endmodule

FILE: hw/rtl/dts_ctrl.sv
// dts_ctrl: runnable/finished sets, action decode and the finish walk over the table.
// Depends on dts_pkg; drives dts_dep_ram through a dep_port_t.
module dts_ctrl
	import dts_pkg::*;
#(
	parameter int FAMILIES = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  req_word_t         req,
	input  logic [((FAMILIES < MASK_W) ? FAMILIES : MASK_W)-1:0] present,
	input  logic [((FAMILIES < MASK_W) ? FAMILIES : MASK_W)-1:0] start,
	input  logic [MASK_W-1:0] dep_rd_data,
	output dep_port_t         dep_port,
	output logic              busy,
	output rsp_word_t         res
);

	localparam int SW = (FAMILIES < MASK_W) ? FAMILIES : MASK_W;
	localparam int IW = $clog2(SW);

	sched_state_t      state_q, state_nx;
	logic [IW-1:0]     cnt_q;
	logic [IW-1:0]     idx_s1;
	logic              valid_s1;
	logic [FAM_W-1:0]  fam_q;
	logic [SW-1:0]     runnable_q, finished_q;

	logic              fam_ok, fam_pres, start_walk, found, hit;
	logic [IW-1:0]     famx, gidx;
	logic [MASK_W-1:0] fin_ext;

	// decode and lowest runnable search
	always_comb begin
		fam_ok   = (32'(req.family) < FAMILIES);
		famx     = req.family[IW-1:0];
		fam_pres = fam_ok && present[famx];
		found    = |runnable_q;
		gidx     = '0;
		for (int i = SW - 1; i >= 0; i--) begin
			if (runnable_q[i]) begin
				gidx = IW'(i);
			end
		end
		start_walk = accept && (req.action == ACT_DONE) && fam_pres;
		fin_ext    = MASK_W'(finished_q);
		hit = present[idx_s1] && dep_rd_data[fam_q] && ((fin_ext & dep_rd_data) == dep_rd_data);
	end

	always_comb begin
		res = '0;
		if (req.action == ACT_NEXT) begin
			res.task_valid    = found;
			res.task_family   = found ? FAM_W'(gidx) : '0;
			res.still_pending = found || (present != finished_q);
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start_walk) state_nx = ST_WALK;
			end
			ST_WALK: begin
				if (cnt_q == IW'(SW - 1)) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		dep_port         = '0;
		dep_port.wr_en   = accept && (req.action == ACT_LOAD) && fam_ok;
		dep_port.wr_addr = req.family;
		dep_port.wr_data = req.dep_mask;
		dep_port.rd_en   = (state_q == ST_WALK);
		dep_port.rd_addr = FAM_W'(cnt_q);
		busy = (state_q != ST_IDLE) || valid_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_nx;
			valid_s1 <= dep_port.rd_en;
			if (state_q == ST_WALK) cnt_q <= cnt_q + IW'(1);
			else cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (start_walk) fam_q <= req.family;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			runnable_q <= '0;
			finished_q <= '0;
		end else begin
			if (accept) begin
				case (req.action)
					ACT_RESET: begin
						runnable_q <= start;
						finished_q <= '0;
					end
					ACT_NEXT: begin
						if (found) runnable_q[gidx] <= 1'b0;
					end
					ACT_DONE: begin
						if (fam_pres) finished_q[famx] <= 1'b1;
					end
					ACT_RETRY: begin
						if (fam_ok) runnable_q[famx] <= 1'b1;
					end
					default: ;
				endcase
			end
			if (valid_s1 && hit) runnable_q[idx_s1] <= 1'b1;
		end
	end

endmodule
